// ===== src/csl_pkg.sv =====
// shared types and constants for the colour signature table builder
// no dependencies
`timescale 1ns / 1ps

package csl_pkg;

    localparam int CSL_BIN_BITS        = 6;
    localparam int CSL_FRACTION_BITS   = 15;
    localparam int CSL_SIGNATURE_COUNT = 7;

    // widest table address over the whole parameter range
    localparam int CSL_IDX_W = 16;

    typedef enum logic [1:0] {
        OP_WRITE_BOX = 2'd0,
        OP_CLEAR     = 2'd1,
        OP_CLASSIFY  = 2'd2,
        OP_READ      = 2'd3
    } csl_op_t;

    // decoded command handed from front to back
    typedef struct packed {
        csl_op_t                op;
        logic [2:0]             sig;
        logic signed [23:0]     u_low;
        logic signed [23:0]     u_high;
        logic signed [23:0]     v_low;
        logic signed [23:0]     v_high;
        logic                   active;
        logic                   clear_all;
        logic signed [8:0]      diff_rg;
        logic signed [8:0]      diff_bg;
        logic [9:0]             luma;
        logic                   dark;
        logic [CSL_IDX_W-1:0]   index;
    } csl_cmd_t;

    typedef struct packed {
        logic [11:0] entry_index;
        logic [6:0]  entry_value;
        logic [2:0]  matched_sig;
        logic        too_dark;
    } csl_result_t;

endpackage

// ===== src/csl_front.sv =====
// front end: unpacks an input transfer and classifies it into a command
// depends on csl_pkg
`timescale 1ns / 1ps

module csl_front
    import csl_pkg::*;
#(
    parameter int BIN_BITS = CSL_BIN_BITS
) (
    input  logic [143:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic [9:0]   min_brightness,
    output csl_cmd_t     cmd
);

    localparam logic [CSL_IDX_W-1:0] IDX_MASK = CSL_IDX_W'((32'd1 << (2 * BIN_BITS)) - 1);

    logic [7:0]            red, green, blue;
    logic [11:0]           lut_index;
    logic [9:0]            thr;
    logic [2*BIN_BITS-1:0] bin;

    always_comb begin
        red       = s_tdata[107:100];
        green     = s_tdata[115:108];
        blue      = s_tdata[123:116];
        lut_index = s_tdata[135:124];
        thr       = (min_brightness == 10'd0) ? 10'd1 : min_brightness;

        cmd.op        = csl_op_t'(s_tuser);
        cmd.sig       = s_tdata[2:0];
        cmd.u_low     = s_tdata[26:3];
        cmd.u_high    = s_tdata[50:27];
        cmd.v_low     = s_tdata[74:51];
        cmd.v_high    = s_tdata[98:75];
        cmd.active    = s_tdata[99];
        cmd.clear_all = s_tdata[136];
        cmd.diff_rg   = $signed({1'b0, red}) - $signed({1'b0, green});
        cmd.diff_bg   = $signed({1'b0, blue}) - $signed({1'b0, green});
        cmd.luma      = 10'(red) + 10'(green) + 10'(blue);
        cmd.dark      = cmd.luma < thr;
        // bin from the top bits of the colour differences
        bin = {cmd.diff_rg[8 -: BIN_BITS], cmd.diff_bg[8 -: BIN_BITS]};
        if (cmd.op == OP_CLASSIFY) begin
            cmd.index = CSL_IDX_W'(bin);
        end else begin
            cmd.index = CSL_IDX_W'(lut_index) & IDX_MASK;
        end
    end

endmodule

// ===== src/csl_cmd_fifo.sv =====
// two-entry command queue between front and back
// depends on csl_pkg
`timescale 1ns / 1ps

module csl_cmd_fifo
    import csl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  csl_cmd_t din,
    input  logic     pop,
    output csl_cmd_t dout,
    output logic     full,
    output logic     empty
);

    csl_cmd_t   slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== src/csl_div.sv =====
// two-lane restoring divider, four quotient bits per cycle
// standalone, used by csl_back
`timescale 1ns / 1ps

module csl_div #(
    parameter int FRACTION_BITS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [7:0]  mag_u,
    input  logic [7:0]  mag_v,
    input  logic [9:0]  divisor,
    output logic        done,
    output logic [24:0] quo_u,
    output logic [24:0] quo_v
);

    localparam int DW    = 8 + FRACTION_BITS;
    localparam int STEPS = (DW + 3) / 4;
    localparam int PW    = STEPS * 4;
    localparam int CW    = $clog2(STEPS + 1);

    logic [PW-1:0] num_u_reg, num_v_reg, q_u_reg, q_v_reg;
    logic [9:0]    rem_u_reg, rem_v_reg, div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;

    logic [PW-1:0] num_u_next, num_v_next, q_u_next, q_v_next;
    logic [9:0]    rem_u_next, rem_v_next;
    logic [10:0]   tu, tv;

    always_comb begin
        num_u_next = num_u_reg;
        num_v_next = num_v_reg;
        q_u_next   = q_u_reg;
        q_v_next   = q_v_reg;
        rem_u_next = rem_u_reg;
        rem_v_next = rem_v_reg;
        tu = '0;
        tv = '0;
        for (int k = 0; k < 4; k++) begin
            tu = {rem_u_next, num_u_next[PW-1]};
            tv = {rem_v_next, num_v_next[PW-1]};
            num_u_next = num_u_next << 1;
            num_v_next = num_v_next << 1;
            if (tu >= {1'b0, div_reg}) begin
                rem_u_next = 10'(tu - {1'b0, div_reg});
                q_u_next   = {q_u_next[PW-2:0], 1'b1};
            end else begin
                rem_u_next = tu[9:0];
                q_u_next   = {q_u_next[PW-2:0], 1'b0};
            end
            if (tv >= {1'b0, div_reg}) begin
                rem_v_next = 10'(tv - {1'b0, div_reg});
                q_v_next   = {q_v_next[PW-2:0], 1'b1};
            end else begin
                rem_v_next = tv[9:0];
                q_v_next   = {q_v_next[PW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CW'(1));
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= CW'(STEPS);
                num_u_reg <= PW'({mag_u, {FRACTION_BITS{1'b0}}});
                num_v_reg <= PW'({mag_v, {FRACTION_BITS{1'b0}}});
                q_u_reg   <= '0;
                q_v_reg   <= '0;
                rem_u_reg <= '0;
                rem_v_reg <= '0;
                div_reg   <= divisor;
            end else if (busy_reg) begin
                num_u_reg <= num_u_next;
                num_v_reg <= num_v_next;
                q_u_reg   <= q_u_next;
                q_v_reg   <= q_v_next;
                rem_u_reg <= rem_u_next;
                rem_v_reg <= rem_v_next;
                cnt_reg   <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done  = done_reg;
    assign quo_u = 25'(q_u_reg);
    assign quo_v = 25'(q_v_reg);

endmodule

// ===== src/csl_back.sv =====
// back end: boxes, chroma table, divider sequencing and output register
// depends on csl_pkg and csl_div
`timescale 1ns / 1ps

module csl_back
    import csl_pkg::*;
#(
    parameter int BIN_BITS        = CSL_BIN_BITS,
    parameter int FRACTION_BITS   = CSL_FRACTION_BITS,
    parameter int SIGNATURE_COUNT = CSL_SIGNATURE_COUNT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  csl_cmd_t    cmd,
    input  logic        cmd_empty,
    output logic        cmd_pop,
    output logic        clear_done,
    output logic        m_valid,
    input  logic        m_ready,
    output csl_result_t m_result
);

    localparam int AW    = 2 * BIN_BITS;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = SIGNATURE_COUNT;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_DIV, ST_EXEC, ST_OUT
    } state_t;

    state_t state_reg;

    logic [SW-1:0] lut_mem [DEPTH];
    logic [SW-1:0] rdata_reg;

    logic signed [24:0] box_u_low_reg  [SW];
    logic signed [24:0] box_u_high_reg [SW];
    logic signed [24:0] box_v_low_reg  [SW];
    logic signed [24:0] box_v_high_reg [SW];
    logic [SW-1:0]      box_en_reg;

    logic [AW-1:0] clr_cnt_reg;
    csl_cmd_t      cmd_reg;
    logic          hit_reg;
    logic [2:0]    hit_sig_reg;
    csl_result_t   res_reg, m_res_reg;
    logic          m_valid_reg;

    // divider hookup
    logic        div_start, div_done;
    logic [24:0] quo_u, quo_v;
    logic [7:0]  mag_u, mag_v;
    logic signed [24:0] u_val, v_val;

    // match and execute logic
    logic          hit;
    logic [2:0]    hit_sig;
    logic [SW-1:0] sig_mask, hit_bit, new_val;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    csl_result_t   exec_res;

    assign cmd_pop    = (state_reg == ST_IDLE) && !cmd_empty;
    assign clear_done = state_reg != ST_CLEAR;
    assign div_start  = cmd_pop && (cmd.op == OP_CLASSIFY) && !cmd.dark;
    assign mag_u = cmd.diff_rg[8] ? 8'(-cmd.diff_rg) : cmd.diff_rg[7:0];
    assign mag_v = cmd.diff_bg[8] ? 8'(-cmd.diff_bg) : cmd.diff_bg[7:0];

    csl_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag_u   (mag_u),
        .mag_v   (mag_v),
        .divisor (cmd.luma),
        .done    (div_done),
        .quo_u   (quo_u),
        .quo_v   (quo_v)
    );

    // truncating signed quotient: divide magnitudes, then restore sign
    assign u_val = cmd_reg.diff_rg[8] ? -$signed(quo_u) : $signed(quo_u);
    assign v_val = cmd_reg.diff_bg[8] ? -$signed(quo_v) : $signed(quo_v);

    // lowest enabled box that strictly holds the point wins
    always_comb begin
        hit     = 1'b0;
        hit_sig = '0;
        for (int s = SW - 1; s >= 0; s--) begin
            if (box_en_reg[s] && box_u_low_reg[s] < u_val && u_val < box_u_high_reg[s] &&
                box_v_low_reg[s] < v_val && v_val < box_v_high_reg[s]) begin
                hit     = 1'b1;
                hit_sig = 3'(s);
            end
        end
    end

    always_comb begin
        for (int b = 0; b < SW; b++) begin
            sig_mask[b] = cmd_reg.sig == 3'(b);
            hit_bit[b]  = hit_sig_reg == 3'(b);
        end
        new_val  = rdata_reg;
        mem_we   = 1'b0;
        exec_res = '0;
        exec_res.entry_index = 12'(cmd_reg.index);
        case (cmd_reg.op)
            OP_CLEAR: begin
                new_val = cmd_reg.clear_all ? '0 : (rdata_reg & ~sig_mask);
                mem_we  = 1'b1;
            end
            OP_CLASSIFY: begin
                if (cmd_reg.dark) begin
                    exec_res.too_dark = 1'b1;
                end else if (hit_reg) begin
                    if (rdata_reg == '0 || rdata_reg > hit_bit) begin
                        new_val = hit_bit;
                    end
                    mem_we = 1'b1;
                    exec_res.matched_sig = 3'({1'b0, hit_sig_reg} + 4'd1);
                end
            end
            default: begin
            end
        endcase
        exec_res.entry_value = 7'(new_val);

        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = mem_we && (state_reg == ST_EXEC);
            mem_waddr = cmd_reg.index[AW-1:0];
            mem_wdata = new_val;
        end
    end

    // chroma table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            lut_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd_pop) begin
            rdata_reg <= lut_mem[cmd.index[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            box_en_reg  <= '0;
            hit_reg     <= 1'b0;
            for (int s = 0; s < SW; s++) begin
                box_u_low_reg[s]  <= '0;
                box_u_high_reg[s] <= '0;
                box_v_low_reg[s]  <= '0;
                box_v_high_reg[s] <= '0;
            end
        end else begin
            // in ST_OUT the output register is handled by the state itself
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (cmd_pop) begin
                        cmd_reg <= cmd;
                        hit_reg <= 1'b0;
                        if (cmd.op == OP_WRITE_BOX) begin
                            for (int s = 0; s < SW; s++) begin
                                if (cmd.sig == 3'(s)) begin
                                    box_u_low_reg[s]  <= 25'(cmd.u_low);
                                    box_u_high_reg[s] <= 25'(cmd.u_high);
                                    box_v_low_reg[s]  <= 25'(cmd.v_low);
                                    box_v_high_reg[s] <= 25'(cmd.v_high);
                                    box_en_reg[s]     <= cmd.active;
                                end
                            end
                            res_reg   <= '0;
                            state_reg <= ST_OUT;
                        end else if (div_start) begin
                            state_reg <= ST_DIV;
                        end else begin
                            state_reg <= ST_EXEC;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        hit_reg     <= hit;
                        hit_sig_reg <= hit_sig;
                        state_reg   <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    res_reg   <= exec_res;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_res_reg   <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_res_reg;

endmodule

// ===== src/color_signature_lut_builder_core.sv =====
// top level of the colour signature table builder
// depends on csl_pkg, csl_front, csl_cmd_fifo, csl_back
`timescale 1ns / 1ps

// usage
//   the s_ stream carries commands: write a signature box, clear a table
//   entry (one bit or all), classify an rgb sweep point, or read an entry.
//   the opcode travels in s_tuser. every command gives exactly one transfer
//   on the m_ stream: entry index, entry value after the operation and the
//   matched signature number in m_tdata, the too-dark flag in m_tuser.
//   min_brightness sits at byte address 0 of the apb port.
// command flow
//   a box write passes from the queue through ST_IDLE and ST_OUT to the
//   output register; clear, read and a dark classify also pass through
//   ST_EXEC. a bright classify waits in ST_DIV for the two-lane divider
//   (four quotient bits a cycle). the back end works on one command at a
//   time; a two-entry queue lets the front keep accepting.
// reset
//   boxes are cleared and min_brightness goes to 1. the chroma table is then
//   swept to zero, one entry a cycle over all 1<<(2*BIN_BITS) entries (4096 at the
//   default), while s_tready stays low; apb writes are taken throughout.
// backpressure
//   a result waits in the output register while m_tready is low; the back
//   end holds behind it and the queue fills before s_tready drops.

module color_signature_lut_builder_core
    import csl_pkg::*;
#(
    parameter int BIN_BITS        = CSL_BIN_BITS,
    parameter int FRACTION_BITS   = CSL_FRACTION_BITS,
    parameter int SIGNATURE_COUNT = CSL_SIGNATURE_COUNT
) (
    input  logic         aclk,
    input  logic         aresetn,
    // command stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // sig_index[2:0], u_low[26:3], u_high[50:27], v_low[74:51], v_high[98:75],
    // sig_active[99], red[107:100], green[115:108], blue[123:116],
    // lut_index[135:124], clear_all[136], zero fill above
    input  logic [143:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_index[11:0], entry_value[18:12], matched_sig[21:19], zero fill above
    output logic [23:0]  m_tdata,
    // too_dark[0]
    output logic [0:0]   m_tuser,
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [9:0]  min_bright_reg;
    csl_cmd_t    front_cmd, head_cmd;
    logic        fifo_full, fifo_empty, fifo_push, fifo_pop;
    logic        clear_done;
    csl_result_t result;

    // register file: one register, index taken from paddr[2]
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(min_bright_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_bright_reg <= 10'd1;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            min_bright_reg <= pwdata[9:0];
        end
    end

    // front: decode and classify the incoming transfer
    csl_front #(
        .BIN_BITS (BIN_BITS)
    ) u_front (
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .min_brightness (min_bright_reg),
        .cmd            (front_cmd)
    );

    // no commands taken until the table sweep has finished
    assign s_tready  = !fifo_full && clear_done;
    assign fifo_push = s_tvalid && s_tready;

    csl_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fifo_push),
        .din     (front_cmd),
        .pop     (fifo_pop),
        .dout    (head_cmd),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    // back: table, boxes, divider and output register
    csl_back #(
        .BIN_BITS        (BIN_BITS),
        .FRACTION_BITS   (FRACTION_BITS),
        .SIGNATURE_COUNT (SIGNATURE_COUNT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (head_cmd),
        .cmd_empty  (fifo_empty),
        .cmd_pop    (fifo_pop),
        .clear_done (clear_done),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_result   (result)
    );

    assign m_tdata = {2'b00, result.matched_sig, result.entry_value, result.entry_index};
    assign m_tuser = result.too_dark;

endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for color_signature_lut_builder_core: directed table, then random traffic
// depends on csl_pkg and the core rtl
`timescale 1ns / 1ps

module tb_top;
    import csl_pkg::*;

    localparam int BINB = 6;
    localparam int FRAC = 15;
    localparam int NSIG = 7;
    localparam int NRANDOM = 930;

    // stimulus row of the directed table; want_* used only when has_want is set
    typedef struct {
        csl_op_t     op;
        logic [2:0]  sig;
        logic [23:0] ul, uh, vl, vh;
        logic        act;
        logic [7:0]  r, g, b;
        logic [11:0] idx;
        logic        clr_all;
        logic        has_want;
        csl_result_t want;
    } cmd_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    color_signature_lut_builder_core dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic signed [24:0] bx_ul[NSIG], bx_uh[NSIG], bx_vl[NSIG], bx_vh[NSIG];
    logic               bx_en[NSIG];
    logic [6:0]         chroma_bits[4096];
    logic [9:0]         bright_floor;

    csl_result_t pending_results[$];
    int errors = 0;
    int results_seen = 0;
    int dark_seen = 0, match_seen = 0;
    int quiet_phase = 0;   // 1 disables idling on both sides
    int cmd_count = 0;

    // one command through the predictor, returns the result it should give
    function automatic csl_result_t classify_and_update(cmd_row_t c);
        csl_result_t res;
        logic [11:0] bin;
        int ri, gi, bi, y, thr, u, v, drg, dbg;
        res = '0;
        case (c.op)
            OP_WRITE_BOX: begin
                if (c.sig < NSIG) begin
                    bx_ul[c.sig] = $signed(c.ul);
                    bx_uh[c.sig] = $signed(c.uh);
                    bx_vl[c.sig] = $signed(c.vl);
                    bx_vh[c.sig] = $signed(c.vh);
                    bx_en[c.sig] = c.act;
                end
            end
            OP_CLEAR: begin
                if (c.clr_all) chroma_bits[c.idx] = '0;
                else if (c.sig < NSIG) chroma_bits[c.idx] &= ~(7'(1) << c.sig);
                res.entry_index = c.idx;
                res.entry_value = chroma_bits[c.idx];
            end
            OP_CLASSIFY: begin
                ri = c.r; gi = c.g; bi = c.b;
                y = ri + gi + bi;
                thr = (bright_floor == 0) ? 1 : bright_floor;
                drg = ri - gi;
                dbg = bi - gi;
                bin = {6'(drg >>> (9 - BINB)), 6'(dbg >>> (9 - BINB))};
                if (y < thr) begin
                    res.too_dark = 1'b1;
                end else begin
                    u = (drg * (1 << FRAC)) / y;
                    v = (dbg * (1 << FRAC)) / y;
                    for (int s = 0; s < NSIG; s++) begin
                        if (bx_en[s] && bx_ul[s] < u && u < bx_uh[s]
                            && bx_vl[s] < v && v < bx_vh[s]) begin
                            if (chroma_bits[bin] == 0 || chroma_bits[bin] > (7'(1) << s))
                                chroma_bits[bin] = 7'(1) << s;
                            res.matched_sig = 3'(s + 1);
                            break;
                        end
                    end
                end
                res.entry_index = bin;
                res.entry_value = chroma_bits[bin];
            end
            default: begin
                res.entry_index = c.idx;
                res.entry_value = chroma_bits[c.idx];
            end
        endcase
        return res;
    endfunction

    // apb write, setup then access, at falling edges
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val; penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'd0) bright_floor = val[9:0];
    endtask

    // wait until every expected transfer is back, then let the pipe drain
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // send one command; checks typed result against predictor when given
    // tvalid stays high between back-to-back commands outside random idles, drain_results drops it
    task automatic send_cmd(input cmd_row_t c);
        csl_result_t exp_res;
        exp_res = classify_and_update(c);
        if (c.has_want && exp_res != c.want) begin
            $display("%0t directed row disagrees with predictor: expected %h actual %h",
                     $time, c.want, exp_res);
            errors++;
        end
        while (quiet_phase == 0 && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= {7'd0, c.clr_all, c.idx, c.b, c.g, c.r, c.act,
                    c.vh, c.vl, c.uh, c.ul, c.sig};
        s_tuser <= c.op;
        s_tvalid <= 1'b1;
        pending_results = {pending_results, exp_res};
        do @(posedge aclk); while (!s_tready);
        cmd_count++;
        @(negedge aclk);
    endtask

    function automatic cmd_row_t blank_row(csl_op_t op);
        cmd_row_t c;
        c = '{op: op, sig: 3'd0, ul: '0, uh: '0, vl: '0, vh: '0, act: 1'b0,
              r: '0, g: '0, b: '0, idx: '0, clr_all: 1'b0, has_want: 1'b0, want: '0};
        return c;
    endfunction

    function automatic cmd_row_t box_row(int sig, int ul, int uh, int vl, int vh, bit act);
        cmd_row_t c;
        c = blank_row(OP_WRITE_BOX);
        c.sig = 3'(sig); c.ul = 24'(ul); c.uh = 24'(uh); c.vl = 24'(vl); c.vh = 24'(vh);
        c.act = act;
        c.has_want = 1'b1;
        return c;
    endfunction

    function automatic cmd_row_t point_row(int r, int g, int b);
        cmd_row_t c;
        c = blank_row(OP_CLASSIFY);
        c.r = 8'(r); c.g = 8'(g); c.b = 8'(b);
        return c;
    endfunction

    function automatic int rand_bound();
        // mix of full range and values near the point's real span
        if ($urandom_range(3) == 0) return $signed(24'($urandom));
        return int'($urandom_range(2 * 98304)) - 98304;
    endfunction

    function automatic cmd_row_t random_row();
        cmd_row_t c;
        int k, lo, hi;
        k = $urandom_range(99);
        c = blank_row(OP_CLASSIFY);
        c.sig = 3'($urandom); c.idx = 12'($urandom); c.clr_all = 1'($urandom);
        c.r = 8'($urandom); c.g = 8'($urandom); c.b = 8'($urandom); c.act = 1'($urandom);
        c.ul = 24'($urandom); c.uh = 24'($urandom); c.vl = 24'($urandom);
        c.vh = 24'($urandom);
        if (k < 8) begin
            c.op = OP_WRITE_BOX;
            if ($urandom_range(3) != 0) begin
                lo = rand_bound(); hi = lo + $urandom_range(98304);
                c.ul = 24'(lo); c.uh = 24'(hi);
                lo = rand_bound(); hi = lo + $urandom_range(98304);
                c.vl = 24'(lo); c.vh = 24'(hi);
                c.act = ($urandom_range(4) != 0);
            end
        end else if (k < 16) begin
            c.op = OP_CLEAR;
        end else if (k < 28) begin
            c.op = OP_READ;
            if ($urandom_range(1)) c.idx = {6'(int'(c.r) - int'(c.g) >>> 3),
                                            6'(int'(c.b) - int'(c.g) >>> 3)};
        end
        return c;
    endfunction

    // result side: random stall, compare at rising edge
    always @(negedge aclk) begin
        if (aresetn) m_tready <= (quiet_phase != 0) || ($urandom_range(99) >= 16);
    end

    always @(posedge aclk) begin
        csl_result_t got, exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            got.entry_index = m_tdata[11:0];
            got.entry_value = m_tdata[18:12];
            got.matched_sig = m_tdata[21:19];
            got.too_dark    = m_tuser[0];
            results_seen++;
            if (got.too_dark) dark_seen++;
            if (got.matched_sig != 0) match_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result transfer: expected none actual %h", $time, got);
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (got.entry_index != exp_res.entry_index)
                    $display("%0t entry_index mismatch: expected %0d actual %0d",
                             $time, exp_res.entry_index, got.entry_index);
                if (got.entry_value != exp_res.entry_value)
                    $display("%0t entry_value mismatch: expected %h actual %h",
                             $time, exp_res.entry_value, got.entry_value);
                if (got.matched_sig != exp_res.matched_sig)
                    $display("%0t matched_sig mismatch: expected %0d actual %0d",
                             $time, exp_res.matched_sig, got.matched_sig);
                if (got.too_dark != exp_res.too_dark)
                    $display("%0t too_dark mismatch: expected %0d actual %0d",
                             $time, exp_res.too_dark, got.too_dark);
                if (got != exp_res) errors++;
            end
        end
    end

    // watchdog
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        cmd_row_t dir_rows[$];
        cmd_row_t c;
        csl_result_t w;
        int floors[5];

        for (int s = 0; s < NSIG; s++) begin
            bx_ul[s] = 0; bx_uh[s] = 0; bx_vl[s] = 0; bx_vh[s] = 0; bx_en[s] = 0;
        end
        foreach (chroma_bits[i]) chroma_bits[i] = '0;
        bright_floor = 10'd1;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows: read after reset, extreme boxes, every opcode
        c = blank_row(OP_READ); c.idx = 12'hfff; c.has_want = 1'b1;
        c.want.entry_index = 12'hfff; dir_rows = {dir_rows, c};
        c = blank_row(OP_READ); c.idx = 12'h000; c.has_want = 1'b1; dir_rows = {dir_rows, c};
        // black point, dark at reset threshold
        c = point_row(0, 0, 0); c.has_want = 1'b1;
        w = '0; w.too_dark = 1'b1; c.want = w; dir_rows = {dir_rows, c};
        dir_rows = {dir_rows, box_row(0, -8355840, 8355840, -8355840, 8355840, 1)};
        dir_rows = {dir_rows, box_row(1, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 1)};
        dir_rows = {dir_rows, box_row(6, -100, 100, -100, 100, 1)};
        // signature index out of range: ignored write
        dir_rows = {dir_rows, box_row(7, -8355840, 8355840, -8355840, 8355840, 1)};
        dir_rows = {dir_rows, point_row(255, 255, 255)};   // grey, signature 1 wins
        dir_rows = {dir_rows, point_row(255, 0, 0)};
        dir_rows = {dir_rows, point_row(0, 255, 0)};
        dir_rows = {dir_rows, point_row(0, 0, 255)};
        dir_rows = {dir_rows, point_row(1, 0, 0)};
        dir_rows = {dir_rows, box_row(0, 0, 0, 0, 0, 0)};   // disable, signature 2 takes over
        dir_rows = {dir_rows, point_row(128, 0, 255)};
        dir_rows = {dir_rows, point_row(255, 255, 255)};   // lower bit wins, kept
        c = blank_row(OP_CLEAR); c.idx = 12'd0; c.sig = 3'd0; dir_rows = {dir_rows, c};
        c = blank_row(OP_CLEAR); c.idx = 12'd0; c.sig = 3'd7; dir_rows = {dir_rows, c};
        c = blank_row(OP_CLEAR); c.idx = 12'd0; c.clr_all = 1'b1; c.has_want = 1'b1;
        dir_rows = {dir_rows, c};
        c = blank_row(OP_CLEAR); c.idx = 12'hfff; c.sig = 3'd6; dir_rows = {dir_rows, c};
        c = blank_row(OP_READ); c.idx = 12'd0; c.has_want = 1'b1; dir_rows = {dir_rows, c};

        foreach (dir_rows[i]) send_cmd(dir_rows[i]);
        drain_results();

        // a few threshold settings, extremes included; zero acts as one
        floors = '{765, 0, 300, 1, 1023};
        for (int ph = 0; ph < 5; ph++) begin
            reg_write(3'd0, floors[ph]);
            c = point_row(255, 255, 255); send_cmd(c);
            c = point_row(255, 255, 254); send_cmd(c);
            quiet_phase = (ph == 2);
            for (int n = 0; n < NRANDOM / 5; n++) begin
                send_cmd(random_row());
                if (n == 50 && ph == 1) drain_results();
            end
            quiet_phase = 0;
            drain_results();
        end

        $display("covered %0d commands, %0d results, %0d dark points, %0d matches",
                 cmd_count, results_seen, dark_seen, match_seen);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/csl_pkg.sv
src/csl_front.sv
src/csl_cmd_fifo.sv
src/csl_div.sv
src/csl_back.sv
src/color_signature_lut_builder_core.sv
tb/tb_top.sv
